// ===== rtl/sfd_pkg.sv =====
// types and constants shared by the setpoint fifo files
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int SFD_DEPTH      = 64;
    localparam int SETPOINT_WIDTH = 64;
    localparam int COUNT_WIDTH    = 32;
    localparam int OCC_WIDTH      = 7;
    localparam int ACTION_WIDTH   = 3;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 7;
    localparam int CAP_DEFAULT    = 64;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_PUSH        = 3'd0,
        ACT_POP         = 3'd1,
        ACT_CLEAR       = 3'd2,
        ACT_UNDERRUN    = 3'd3,
        ACT_SHORT_START = 3'd4
    } sfd_action_t;

    typedef enum logic [1:0] {
        OUT_STORED  = 2'd0,
        OUT_EVICTED = 2'd1,
        OUT_DROPPED = 2'd2,
        OUT_NONE    = 2'd3
    } sfd_outcome_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_CAPACITY    = 2'd0,
        REG_DROP_OLDEST = 2'd1
    } sfd_reg_idx_t;

    typedef struct packed {
        logic [ACTION_WIDTH-1:0]   action;
        logic [SETPOINT_WIDTH-1:0] setpoint_data;
    } sfd_item_t;

    typedef struct packed {
        logic                      popped_valid;
        logic [SETPOINT_WIDTH-1:0] popped_setpoint;
        sfd_outcome_t              push_outcome;
        logic [OCC_WIDTH-1:0]      occupancy;
        logic [COUNT_WIDTH-1:0]    pushed_total;
        logic [COUNT_WIDTH-1:0]    dropped_total;
        logic [COUNT_WIDTH-1:0]    underrun_total;
        logic [COUNT_WIDTH-1:0]    short_start_total;
    } sfd_result_t;

endpackage

// ===== rtl/sfd_store.sv =====
// setpoint entry memory, one write and one registered read port
`timescale 1ns / 1ps

module sfd_store
    import sfd_pkg::*;
#(
    parameter int DEPTH = SFD_DEPTH
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [SETPOINT_WIDTH-1:0]        wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [SETPOINT_WIDTH-1:0]        rd_data
);

    logic [SETPOINT_WIDTH-1:0] store_mem [DEPTH];
    logic [SETPOINT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/setpoint_fifo_with_drop_policy_unit.sv =====
// top level of the bounded setpoint fifo with drop policy and event totals
`timescale 1ns / 1ps
// an item passes the input register and then the result register; result_ready can stall it
// throughput: 1 transaction per cycle while result_ready does not stall, set by
//   the pointer/count update and the one-port registered read of the entry memory
// reset: async active low, clears pointers, count, totals and handshake state,
//   capacity returns to min(64, DEPTH) and drop policy to discard-new; memory is not cleared

module setpoint_fifo_with_drop_policy_unit
    import sfd_pkg::*;
#(
    parameter int DEPTH = SFD_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  sfd_item_t                 item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output sfd_result_t               result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [OCC_WIDTH-1:0] DEPTH_OCC = OCC_WIDTH'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [OCC_WIDTH-1:0] CAP_RESET =
        OCC_WIDTH'((DEPTH < CAP_DEFAULT) ? DEPTH : CAP_DEFAULT);

    // pointer step with wrap at the physical depth
    function automatic logic [AW-1:0] ptr_advance(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + AW'(1);
    endfunction

    // saturating event counter step
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // input stage
    logic      stage_valid_reg;
    sfd_item_t stage_item_reg;

    // result stage, payload comes from the memory read register
    logic        result_valid_reg;
    sfd_result_t result_reg;

    // queue state
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [OCC_WIDTH-1:0] count_reg, count_next;

    // event totals
    logic [COUNT_WIDTH-1:0] pushed_reg, pushed_next;
    logic [COUNT_WIDTH-1:0] dropped_reg, dropped_next;
    logic [COUNT_WIDTH-1:0] underrun_reg, underrun_next;
    logic [COUNT_WIDTH-1:0] short_start_reg, short_start_next;

    // configuration
    logic [OCC_WIDTH-1:0] cap_reg;
    logic                 drop_oldest_reg;

    logic                      fire;
    logic                      full;
    logic                      mem_wr;
    logic                      pop_hit;
    sfd_outcome_t              outcome;
    logic [SETPOINT_WIDTH-1:0] mem_rd_data;
    logic [AW-1:0]             ptr_span;

    // the stage item moves into the result register when that slot is free or draining
    assign fire       = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || fire;
    assign cfg_ready  = 1'b1;

    assign full = (count_reg >= cap_reg);

    // one item's effect on pointers, count and totals
    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        count_next       = count_reg;
        pushed_next      = pushed_reg;
        dropped_next     = dropped_reg;
        underrun_next    = underrun_reg;
        short_start_next = short_start_reg;
        mem_wr           = 1'b0;
        pop_hit          = 1'b0;
        outcome          = OUT_NONE;
        case (stage_item_reg.action)
            ACT_PUSH:
            begin
                if (full)
                begin
                    if (!drop_oldest_reg || (count_reg == '0))
                    begin
                        // discard the incoming setpoint
                        dropped_next = sat_inc(dropped_reg);
                        outcome      = OUT_DROPPED;
                    end
                    else
                    begin
                        // evict oldest and store new, occupancy unchanged
                        rd_ptr_next  = ptr_advance(rd_ptr_reg);
                        wr_ptr_next  = ptr_advance(wr_ptr_reg);
                        mem_wr       = 1'b1;
                        dropped_next = sat_inc(dropped_reg);
                        pushed_next  = sat_inc(pushed_reg);
                        outcome      = OUT_EVICTED;
                    end
                end
                else
                begin
                    // below the limit, so below the physical depth as well
                    wr_ptr_next = ptr_advance(wr_ptr_reg);
                    count_next  = count_reg + OCC_WIDTH'(1);
                    mem_wr      = 1'b1;
                    pushed_next = sat_inc(pushed_reg);
                    outcome     = OUT_STORED;
                end
            end
            ACT_POP:
            begin
                if (count_reg != '0)
                begin
                    rd_ptr_next = ptr_advance(rd_ptr_reg);
                    count_next  = count_reg - OCC_WIDTH'(1);
                    pop_hit     = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                count_next  = '0;
            end
            ACT_UNDERRUN:
            begin
                underrun_next = sat_inc(underrun_reg);
            end
            ACT_SHORT_START:
            begin
                short_start_next = sat_inc(short_start_reg);
            end
            default:
            begin
                // unknown action leaves everything alone
            end
        endcase
    end

    // entry memory, read at the head on every transaction, data used only for pops
    sfd_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (fire && mem_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data (stage_item_reg.setpoint_data),
        .rd_en   (fire),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_rd_data)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.popped_valid      <= pop_hit;
            result_reg.popped_setpoint   <= '0;
            result_reg.push_outcome      <= outcome;
            result_reg.occupancy         <= count_next;
            result_reg.pushed_total      <= pushed_next;
            result_reg.dropped_total     <= dropped_next;
            result_reg.underrun_total    <= underrun_next;
            result_reg.short_start_total <= short_start_next;
        end
    end

    assign result_valid = result_valid_reg;

    // popped payload taken from the memory read register, zero when nothing popped
    always_comb
    begin
        result                 = result_reg;
        result.popped_setpoint = result_reg.popped_valid ? mem_rd_data : '0;
    end

    // queue state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
            pushed_reg      <= '0;
            dropped_reg     <= '0;
            underrun_reg    <= '0;
            short_start_reg <= '0;
        end
        else if (fire)
        begin
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            count_reg       <= count_next;
            pushed_reg      <= pushed_next;
            dropped_reg     <= dropped_next;
            underrun_reg    <= underrun_next;
            short_start_reg <= short_start_next;
        end
    end

    // configuration writes, out-of-range capacity is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= CAP_RESET;
            drop_oldest_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAPACITY:
                begin
                    if ((cfg_data != '0) && (cfg_data <= DEPTH_OCC))
                    begin
                        cap_reg <= cfg_data;
                    end
                end
                REG_DROP_OLDEST:
                begin
                    drop_oldest_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // distance between pointers modulo the physical depth
    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            ptr_span = wr_ptr_reg - rd_ptr_reg;
        end
        else
        begin
            ptr_span = wr_ptr_reg + AW'(DEPTH) - rd_ptr_reg;
        end
    end

    // occupancy never passes the physical depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_OCC)
        else $error("occupancy above depth");

    // pointers agree with the occupancy
    a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_span == ((count_reg == DEPTH_OCC) ? '0 : AW'(count_reg)))
        else $error("pointer distance does not match occupancy");

    // a clear transaction empties the queue and rewinds the pointers
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (stage_item_reg.action == ACT_CLEAR)) |=>
            ((count_reg == '0) && (rd_ptr_reg == '0) && (wr_ptr_reg == '0)))
        else $error("clear did not empty the queue");

    // a popped entry never comes with a push outcome
    a_pop_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.popped_valid) |-> (result.push_outcome == OUT_NONE))
        else $error("pop result carries a push outcome");

endmodule
